>>> sv/assert_macros.svh
// assertion macros used by the top level rtl file
// no dependencies; expands to nothing when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> sv/dtc_pkg.sv
// types, constants and the month length table for the epoch to datetime converter
// no dependencies
package dtc_pkg;

    localparam int unsigned ALU_W = 32;

    // shared multiplier operand and product widths
    localparam int unsigned MUL_A_W = 25;
    localparam int unsigned MUL_B_W = 26;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = 26'd86400;
    localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = 26'd3600;
    localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = 26'd60;

    // reciprocals of the odd part of each divisor (86400 = 675 << 7,
    // 3600 = 225 << 4, 60 = 15 << 2), rounded up, exact over the dividend range
    localparam logic [MUL_B_W-1:0] DAY_RECIP  = 26'd50903317;
    localparam logic [MUL_B_W-1:0] HOUR_RECIP = 26'd9321;
    localparam logic [MUL_B_W-1:0] MIN_RECIP  = 26'd1093;

    // product bit where each quotient starts
    localparam int unsigned DAY_POST  = 35;
    localparam int unsigned HOUR_POST = 21;
    localparam int unsigned MIN_POST  = 14;

    localparam logic [11:0] BASE_YEAR   = 12'd1970;
    localparam logic [8:0]  DAYS_NORMAL = 9'd365;
    localparam logic [1:0]  LEAP_MASK   = 2'd3;
    localparam logic [4:0]  FEB_LEAP    = 5'd29;
    localparam logic [3:0]  LAST_MONTH  = 4'd11;
    localparam logic [3:0]  FEB_INDEX   = 4'd1;

    // subtractor result
    typedef struct packed {
        logic             borrow;
        logic             zero;
        logic [ALU_W-1:0] diff;
    } dtc_alu_res_t;

    // sequencer status toward the output stage
    typedef struct packed {
        logic ready;
        logic res_valid;
    } dtc_status_t;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  sec;
    } dtc_result_t;

    // days in month by zero-based index
    function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
        logic [4:0] len;
        unique case (idx)
            4'd0:    len = 5'd31;
            4'd1:    len = leap ? FEB_LEAP : 5'd28;
            4'd2:    len = 5'd31;
            4'd3:    len = 5'd30;
            4'd4:    len = 5'd31;
            4'd5:    len = 5'd30;
            4'd6:    len = 5'd31;
            4'd7:    len = 5'd31;
            4'd8:    len = 5'd30;
            4'd9:    len = 5'd31;
            4'd10:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

>>> sv/dtc_alu.sv
// shared subtract and compare unit of the converter
// depends on dtc_pkg
module dtc_alu
    import dtc_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    output dtc_alu_res_t     res
);

    logic [ALU_W:0] wide;

    // one subtract gives the difference, the borrow and the equal flag
    assign wide       = {1'b0, a} - {1'b0, b};
    assign res.borrow = wide[ALU_W];
    assign res.diff   = wide[ALU_W-1:0];
    assign res.zero   = (wide[ALU_W-1:0] == '0);

endmodule

>>> sv/dtc_ctrl.sv
// sequencer and working registers: three divisions, year walk, month walk
// depends on dtc_pkg and dtc_alu
module dtc_ctrl
    import dtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] epoch_seconds,
    input  logic        take,
    output dtc_status_t stat,
    output dtc_result_t result
);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DIV_DAY  = 3'd1;
    localparam logic [2:0] ST_DIV_HOUR = 3'd2;
    localparam logic [2:0] ST_DIV_MIN  = 3'd3;
    localparam logic [2:0] ST_YEAR     = 3'd4;
    localparam logic [2:0] ST_MONTH    = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    // steps of one division by a constant
    localparam logic [1:0] STEP_RECIP = 2'd0;
    localparam logic [1:0] STEP_BACK  = 2'd1;
    localparam logic [1:0] STEP_SUB   = 2'd2;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       step_reg, step_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      prod_reg, prod_next;
    logic [15:0]      quo_reg, quo_next;
    logic [15:0]      days_reg, days_next;
    logic [11:0]      year_reg, year_next;
    logic [3:0]       mon_reg, mon_next;
    logic [4:0]       hour_reg, hour_next;
    logic [5:0]       minute_reg, minute_next;
    logic [5:0]       sec_reg, sec_next;

    logic [ALU_W-1:0]   alu_a;
    logic [ALU_W-1:0]   alu_b;
    dtc_alu_res_t       alu;
    logic               leap;
    logic [8:0]         ylen;
    logic [4:0]         mlen;
    logic               gt;
    logic               div_state;
    logic [MUL_A_W-1:0] recip_a;
    logic [MUL_B_W-1:0] recip_b;
    logic [MUL_B_W-1:0] dvs;
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [MUL_P_W-1:0] mul_p;
    logic [15:0]        recip_quo;

    assign leap      = ((year_reg[1:0] & LEAP_MASK) == 2'd0);
    assign ylen      = DAYS_NORMAL + {8'd0, leap};
    assign mlen      = month_len(mon_reg, leap && (mon_reg == FEB_INDEX));
    assign div_state = (state_reg == ST_DIV_DAY) || (state_reg == ST_DIV_HOUR)
                    || (state_reg == ST_DIV_MIN);

    // operand select for the shared unit
    always_comb
    begin
        alu_a = div_state ? rem_reg : {16'd0, days_reg};
        unique case (state_reg)
            ST_YEAR:  alu_b = {23'd0, ylen};
            ST_MONTH: alu_b = {27'd0, mlen};
            default:  alu_b = prod_reg;
        endcase
    end

    dtc_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu)
    );

    // dividend with the divisor's power of two dropped, reciprocal and divisor
    always_comb
    begin
        unique case (state_reg)
            ST_DIV_HOUR:
            begin
                recip_a = {12'd0, rem_reg[16:4]};
                recip_b = HOUR_RECIP;
                dvs     = SECS_PER_HOUR;
            end
            ST_DIV_MIN:
            begin
                recip_a = {15'd0, rem_reg[11:2]};
                recip_b = MIN_RECIP;
                dvs     = SECS_PER_MIN;
            end
            default:
            begin
                recip_a = rem_reg[31:7];
                recip_b = DAY_RECIP;
                dvs     = SECS_PER_DAY;
            end
        endcase
    end

    // shared multiplier: quotient by reciprocal, then quotient times divisor
    assign mul_a = (step_reg == STEP_RECIP) ? recip_a : {9'd0, quo_reg};
    assign mul_b = (step_reg == STEP_RECIP) ? recip_b : dvs;
    assign mul_p = {26'd0, mul_a} * {25'd0, mul_b};

    // quotient field of the product
    always_comb
    begin
        unique case (state_reg)
            ST_DIV_HOUR: recip_quo = {11'd0, mul_p[HOUR_POST+4:HOUR_POST]};
            ST_DIV_MIN:  recip_quo = {10'd0, mul_p[MIN_POST+5:MIN_POST]};
            default:     recip_quo = mul_p[DAY_POST+15:DAY_POST];
        endcase
    end

    // greater-than test for the year and month walks
    assign gt = !alu.borrow && !alu.zero;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        quo_next    = quo_reg;
        days_next   = days_reg;
        year_next   = year_reg;
        mon_next    = mon_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        sec_next    = sec_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    rem_next   = epoch_seconds;
                    step_next  = STEP_RECIP;
                    state_next = ST_DIV_DAY;
                end
            end
            ST_DIV_DAY, ST_DIV_HOUR, ST_DIV_MIN:
            begin
                unique case (step_reg)
                    STEP_RECIP:
                    begin
                        quo_next  = recip_quo;
                        step_next = STEP_BACK;
                    end
                    STEP_BACK:
                    begin
                        prod_next = mul_p[31:0];
                        step_next = STEP_SUB;
                    end
                    default:
                    begin
                        rem_next  = alu.diff;
                        step_next = STEP_RECIP;
                        priority if (state_reg == ST_DIV_DAY)
                        begin
                            days_next  = quo_reg + 16'd1;
                            state_next = ST_DIV_HOUR;
                        end
                        else if (state_reg == ST_DIV_HOUR)
                        begin
                            hour_next  = quo_reg[4:0];
                            state_next = ST_DIV_MIN;
                        end
                        else
                        begin
                            minute_next = quo_reg[5:0];
                            sec_next    = alu.diff[5:0];
                            year_next   = BASE_YEAR;
                            state_next  = ST_YEAR;
                        end
                    end
                endcase
            end
            ST_YEAR:
            begin
                if (gt)
                begin
                    days_next = alu.diff[15:0];
                    year_next = year_reg + 12'd1;
                end
                else
                begin
                    mon_next   = 4'd0;
                    state_next = ST_MONTH;
                end
            end
            ST_MONTH:
            begin
                if (gt)
                begin
                    days_next = alu.diff[15:0];
                end
                if (!gt || (mon_reg == LAST_MONTH))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    mon_next = mon_reg + 4'd1;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= STEP_RECIP;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        quo_reg    <= quo_next;
        days_reg   <= days_next;
        year_reg   <= year_next;
        mon_reg    <= mon_next;
        hour_reg   <= hour_next;
        minute_reg <= minute_next;
        sec_reg    <= sec_next;
    end

    assign stat.ready     = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);

    assign result.year   = year_reg;
    assign result.month  = mon_reg + 4'd1;
    assign result.day    = days_reg[4:0];
    assign result.hour   = hour_reg;
    assign result.minute = minute_reg;
    assign result.sec    = sec_reg;

endmodule

>>> sv/epoch_seconds_to_datetime.sv
// top level of the epoch seconds to calendar datetime converter
// depends on dtc_pkg, dtc_ctrl and assert_macros.svh
//
//  channel  | signals                              | transfer when
//  ---------+--------------------------------------+----------------------
//  input    | in_valid, in_ready, epoch_seconds    | in_valid & in_ready
//  output   | out_valid, out_ready, year .. second | out_valid & out_ready
//
// From input transfer to stored result: three divisions by constants, each as a
// reciprocal multiply, a back multiply and a subtract, then a year walk that
// steps one year at a time past 1970 (up to 136 years) and a month walk that steps
// one month at a time, each walk closed by a final compare, and a done state that
// stores the result. in_ready is high only while idle, which the sequencer enters
// as the result is stored; a stalled output holds the sequencer only while the
// output register is full. reset clears the sequencer and the output valid flag only.
`include "assert_macros.svh"

module epoch_seconds_to_datetime
    import dtc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] epoch_seconds,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] year,
    output logic [3:0]  month,
    output logic [4:0]  day,
    output logic [4:0]  hour,
    output logic [5:0]  minute,
    output logic [5:0]  sec_of_minute
);

    dtc_status_t stat;
    dtc_result_t result;
    logic        load;
    logic        out_valid_reg, out_valid_next;
    dtc_result_t out_reg;

    assign in_ready = stat.ready;

    dtc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (in_valid && stat.ready),
        .epoch_seconds (epoch_seconds),
        .take          (load),
        .stat          (stat),
        .result        (result)
    );

    // output register takes the result when empty or being drained
    assign load = stat.res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        priority if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign year          = out_reg.year;
    assign month         = out_reg.month;
    assign day           = out_reg.day;
    assign hour          = out_reg.hour;
    assign minute        = out_reg.minute;
    assign sec_of_minute = out_reg.sec;

    // checks
    `ASSERT_PROP(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready)
    `ASSERT_PROP(a_result_held, clk, rst_n, stat.res_valid && out_valid && !out_ready |=> stat.res_valid)
    `ASSERT_PROP(a_month_range, clk, rst_n, out_valid |-> (month >= 4'd1 && month <= 4'd12))
    `ASSERT_NEVER(a_day_zero, clk, rst_n, out_valid && (day == 5'd0))
    `ASSERT_NEVER(a_idle_with_result, clk, rst_n, stat.ready && stat.res_valid)

endmodule
